### src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes of the double-ended queue
// Request and result words, decoded operations and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // Default number of ring slots
  localparam int unsigned DQ_DEPTH = 16;

  // Field widths of the request and result words
  localparam int unsigned REQ_W       = 4;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CNT_FIELD_W = 5;

  // Request codes as they arrive on the input word
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 4'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SIZE       = 4'd6;
  localparam logic [REQ_W-1:0] REQ_WALK_FWD   = 4'd7;
  localparam logic [REQ_W-1:0] REQ_WALK_REV   = 4'd8;
  localparam logic [REQ_W-1:0] REQ_FIND       = 4'd9;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd10;

  // Decoded operation handed from the front to the back
  typedef enum logic [3:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_PEEK_FRONT,
    OP_PEEK_BACK,
    OP_SIZE,
    OP_WALK_FWD,
    OP_WALK_REV,
    OP_FIND,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_NOT_FOUND
  } status_e;

  // Input word
  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] item_value;
  } in_t;

  // Result word
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] out_value;
    logic [CNT_FIELD_W-1:0]    elem_count;
    logic                      last;
  } out_t;

  // Decoded command in the queue between front and back
  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

### src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// A ring of DEPTH slots with head index and count; push, pop, peek, size,
// traverse, find and clear requests, one or more result words each.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (out_t)
//
// Push, size, clear, unknown codes and empty answers: answered straight into the
// result register. Pop and peek: the slot goes through the registered memory read,
// then out from S_LOAD. Traverse: S_RD and S_EV per element; find: S_RD and S_EV per
// element to a hit or the last one; both walk the ring on the one read port.
// A two-word command queue keeps taking requests while the back end works or
// the result register waits on out_ready_i. Reset empties the ring at once.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH = DQ_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Intake and decode
  dq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Execution and result register
  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### src/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front: request intake of the double-ended queue
// Takes request words, decodes them into commands and holds them in a
// two-entry queue until the back end picks them up.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_front import dq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  wire logic cmd_ready_i
);

  localparam logic [1:0] Q_FULL = 2'd2;

  // Map a request code onto an operation; unused codes become no-ops
  function automatic op_e classify(input logic [REQ_W-1:0] req);
    op_e op;
    case (req)
      REQ_PUSH_BACK:  op = OP_PUSH_BACK;
      REQ_PUSH_FRONT: op = OP_PUSH_FRONT;
      REQ_POP_BACK:   op = OP_POP_BACK;
      REQ_POP_FRONT:  op = OP_POP_FRONT;
      REQ_PEEK_FRONT: op = OP_PEEK_FRONT;
      REQ_PEEK_BACK:  op = OP_PEEK_BACK;
      REQ_SIZE:       op = OP_SIZE;
      REQ_WALK_FWD:   op = OP_WALK_FWD;
      REQ_WALK_REV:   op = OP_WALK_REV;
      REQ_FIND:       op = OP_FIND;
      REQ_CLEAR:      op = OP_CLEAR;
      default:        op = OP_NOP;
    endcase
    return op;
  endfunction

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign in_ready_o  = (fill_q != Q_FULL);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the decoded word
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: classify(in_data_i.req_type), value: in_data_i.item_value};
    end
  end

endmodule

`default_nettype wire

### src/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back: execution engine of the double-ended queue
// Owns the slot memory, head index and count; runs each command and drives
// the registered result word. Traverse and find walk the ring one slot at a
// time through the single memory read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_back import dq_pkg::*; #(
  parameter int unsigned DEPTH = DQ_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // take the next command
  localparam logic [1:0] S_LOAD = 2'd1;  // pop/peek data is back from memory
  localparam logic [1:0] S_RD   = 2'd2;  // issue the read of one walk position
  localparam logic [1:0] S_EV   = 2'd3;  // evaluate that slot

  // Ring slot of the element at a given distance from the head
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rd_data_q;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [VALUE_W-1:0] key_q, key_d;
  logic               rev_q, rev_d;
  logic               find_q, find_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;

  logic               out_free, empty, full, is_push, is_last, hit;
  logic [CNT_W-1:0]   count_m1, walk_pos;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign empty    = (count_q == '0);
  assign full     = (count_q >= FULL_CNT);
  assign is_push  = cmd_i.op inside {OP_PUSH_BACK, OP_PUSH_FRONT};
  assign count_m1 = count_q - CNT_W'(1);
  assign walk_pos = rev_q ? (count_m1 - CNT_W'(idx_q)) : CNT_W'(idx_q);
  assign is_last  = (CNT_W'(idx_q) == count_m1);
  assign hit      = (rd_data_q == key_q);
  assign cmd_ready_o = (state_q == S_IDLE) && cmd_valid_i && out_free;

  // Run the sequencer and build the next result word
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    key_d       = key_q;
    rev_d       = rev_q;
    find_d      = find_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    wr_en       = 1'b0;
    wr_addr     = head_q;
    wr_data     = cmd_i.value;

    case (state_q)
      S_IDLE: begin
        if (cmd_ready_o) begin
          out_valid_d      = 1'b1;
          out_d.status     = ST_OK;
          out_d.out_value  = '0;
          out_d.last       = 1'b1;
          if (is_push) begin
            if (full) begin
              out_d.status = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + CNT_W'(1);
              if (cmd_i.op == OP_PUSH_BACK) begin
                wr_addr = slot_at(head_q, count_q[IDX_W-1:0]);
              end else begin
                head_d  = (head_q == '0) ? LAST_SLOT : head_q - IDX_W'(1);
                wr_addr = head_d;
              end
            end
          end else if (cmd_i.op == OP_CLEAR) begin
            head_d  = '0;
            count_d = '0;
          end else if (cmd_i.op inside {OP_POP_BACK, OP_POP_FRONT, OP_PEEK_FRONT,
                                        OP_PEEK_BACK, OP_WALK_FWD, OP_WALK_REV,
                                        OP_FIND}) begin
            if (empty) begin
              out_d.status = ST_EMPTY;
            end else if (cmd_i.op inside {OP_WALK_FWD, OP_WALK_REV, OP_FIND}) begin
              // Start a walk; the result comes later
              out_valid_d = 1'b0;
              idx_d       = '0;
              key_d       = cmd_i.value;
              rev_d       = (cmd_i.op == OP_WALK_REV);
              find_d      = (cmd_i.op == OP_FIND);
              state_d     = S_RD;
            end else begin
              // Pop or peek: read now, deliver from S_LOAD
              out_valid_d = 1'b0;
              rd_en       = 1'b1;
              state_d     = S_LOAD;
              if (cmd_i.op inside {OP_POP_BACK, OP_PEEK_BACK}) begin
                rd_addr = slot_at(head_q, count_m1[IDX_W-1:0]);
              end else begin
                rd_addr = head_q;
              end
              if (cmd_i.op == OP_POP_BACK) begin
                count_d = count_m1;
              end else if (cmd_i.op == OP_POP_FRONT) begin
                head_d  = slot_at(head_q, IDX_W'(1));
                count_d = count_m1;
              end
            end
          end
          out_d.elem_count = CNT_FIELD_W'(count_d);
        end
      end

      S_LOAD: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.status     = ST_OK;
          out_d.out_value  = rd_data_q;
          out_d.elem_count = CNT_FIELD_W'(count_q);
          out_d.last       = 1'b1;
          state_d          = S_IDLE;
        end
      end

      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot_at(head_q, walk_pos[IDX_W-1:0]);
        state_d = S_EV;
      end

      S_EV: begin
        if (find_q && !hit && !is_last) begin
          // Keep searching
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_RD;
        end else if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.elem_count = CNT_FIELD_W'(count_q);
          if (find_q) begin
            out_d.status    = hit ? ST_OK : ST_NOT_FOUND;
            out_d.out_value = '0;
            out_d.last      = 1'b1;
            state_d         = S_IDLE;
          end else begin
            out_d.status    = ST_OK;
            out_d.out_value = rd_data_q;
            out_d.last      = is_last;
            idx_d           = idx_q + IDX_W'(1);
            state_d         = is_last ? S_IDLE : S_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      rev_q       <= 1'b0;
      find_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rev_q       <= rev_d;
      find_q      <= find_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    out_q <= out_d;
  end

  // Slot memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Count never passes the ring size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("dq_back: element count above ring size");

  // An accepted push into a non-full ring adds exactly one element
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_ready_o && is_push && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("dq_back: push did not add one element");

  // A walk only visits positions that hold elements
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV) |-> (CNT_W'(idx_q) < count_q))
    else $error("dq_back: walk index beyond element count");

  // Pop or peek data goes out as soon as the result register is free
  a_load_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("dq_back: read result not delivered");

endmodule

`default_nettype wire
